>>> hdl/ctss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctss_pkg
// Shared types and constants for the color temperature setpoint smoother.
// ----------------------------------------------------------------------------
package ctss_pkg;

  localparam int TEMP_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int FX_W       = TEMP_W + FRAC_BITS;
  localparam int BAND_W     = 10;
  localparam int LEN_W      = 16;
  localparam int PROD_W     = FX_W + LEN_W;
  localparam int DIV_STEPS  = FX_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 40;

  localparam logic [TEMP_W-1:0] DEFAULT_KELVIN = TEMP_W'(6500);
  localparam logic [BAND_W-1:0] DEADBAND_RESET = BAND_W'(10);
  localparam logic [LEN_W-1:0]  RAMP_RESET     = LEN_W'(100);

  localparam logic [KIND_W-1:0] KIND_SMOOTH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IMMEDIATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic div_load;
    logic div_step;
    logic commit;
  } ctss_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } ctss_status_t;

endpackage
`default_nettype wire

>>> hdl/ctss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctss_ctrl
// Sequencer: accepts a transaction, steps the multiply and the divider, and
// commits the result once the output register is free.
// ----------------------------------------------------------------------------
module ctss_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire ctss_pkg::ctss_status_t status,
  output ctss_pkg::ctss_cmd_t        cmd
);
  import ctss_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_EVAL;
      ST_EVAL: state_next = status.need_div ? ST_LOAD : ST_FIN;
      ST_LOAD: state_next = ST_DIV;
      ST_DIV:  if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_FIN;
      ST_FIN:  if (status.out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    cnt_next = cnt;
    unique case (state)
      ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.load_in = s_tvalid;
      end
      ST_EVAL: cmd.mul_en = 1'b1;
      ST_LOAD: begin
        cmd.div_load = 1'b1;
        cnt_next     = '0;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
      end
      ST_FIN: cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/ctss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctss_datapath
// Ramp state, configuration, step multiplier, radix-2 divider and the
// output register.
// ----------------------------------------------------------------------------
module ctss_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [ctss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ctss_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [ctss_pkg::TEMP_W-1:0]       s_tdata,
  input  wire logic [ctss_pkg::KIND_W-1:0]       s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [ctss_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                   m_tuser,
  input  wire ctss_pkg::ctss_cmd_t               cmd,
  output ctss_pkg::ctss_status_t                 status
);
  import ctss_pkg::*;

  logic [BAND_W-1:0] deadband;
  logic [LEN_W-1:0]  ramp_len;
  logic [FX_W-1:0]   last_written, last_written_next;
  logic [TEMP_W-1:0] ramp_target, ramp_target_next;
  logic              ramp_active, ramp_active_next;
  logic [LEN_W-1:0]  elapsed, elapsed_next;

  logic [KIND_W-1:0] kind_q;
  logic [TEMP_W-1:0] temp_q;
  logic [PROD_W-1:0] product;
  logic              dir_up;
  logic [LEN_W-1:0]  rem;
  logic [FX_W-1:0]   quot;

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  elapsed_inc;
  logic [FX_W-1:0]   tgt_fx;
  logic [FX_W-1:0]   temp_fx;
  logic [FX_W-1:0]   band;
  logic              up;
  logic [FX_W-1:0]   span;
  logic [LEN_W:0]    trial;
  logic              ramp_end;
  logic [FX_W-1:0]   offer;
  logic [FX_W-1:0]   offer_diff;
  logic [FX_W-1:0]   set_diff;
  logic              wrote;
  logic [TEMP_W-1:0] shown;

  assign len_eff     = (ramp_len == '0) ? LEN_W'(1) : ramp_len;
  assign elapsed_inc = elapsed + LEN_W'(1);
  assign tgt_fx      = {ramp_target, FRAC_BITS'(0)};
  assign temp_fx     = {temp_q, FRAC_BITS'(0)};
  assign band        = FX_W'({deadband, FRAC_BITS'(0)});
  assign up          = tgt_fx >= last_written;
  assign span        = up ? (tgt_fx - last_written) : (last_written - tgt_fx);
  assign ramp_end    = elapsed_inc >= len_eff;
  assign trial       = {rem, quot[FX_W-1]};

  assign status.need_div = (kind_q == KIND_TICK) && ramp_active && !ramp_end;
  assign status.out_free = !m_tvalid || m_tready;

  always_comb begin
    offer      = ramp_end ? tgt_fx : (dir_up ? last_written + quot : last_written - quot);
    offer_diff = (offer >= last_written) ? (offer - last_written) : (last_written - offer);
    set_diff   = (temp_fx >= last_written) ? (temp_fx - last_written)
                                           : (last_written - temp_fx);
    last_written_next = last_written;
    ramp_target_next  = ramp_target;
    ramp_active_next  = ramp_active;
    elapsed_next      = elapsed;
    wrote             = 1'b0;
    shown             = '0;
    case (kind_q)
      KIND_IMMEDIATE: begin
        ramp_active_next  = 1'b0;
        last_written_next = temp_fx;
        wrote             = 1'b1;
        shown             = temp_q;
      end
      KIND_SMOOTH: begin
        ramp_active_next = 1'b0;
        if (set_diff >= band) begin
          ramp_target_next = temp_q;
          elapsed_next     = '0;
          ramp_active_next = 1'b1;
        end
      end
      KIND_TICK: begin
        if (ramp_active) begin
          elapsed_next = elapsed_inc;
          if (ramp_end) ramp_active_next = 1'b0;
          if (offer_diff > band) begin
            last_written_next = offer;
            wrote             = 1'b1;
            shown             = offer[FX_W-1:FRAC_BITS];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband     <= DEADBAND_RESET;
      ramp_len     <= RAMP_RESET;
      last_written <= {DEFAULT_KELVIN, FRAC_BITS'(0)};
      ramp_target  <= DEFAULT_KELVIN;
      ramp_active  <= 1'b0;
      elapsed      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEADBAND:   deadband <= cfg_data[BAND_W-1:0];
          CFG_RAMP_TICKS: ramp_len <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (cmd.commit) begin
        last_written <= last_written_next;
        ramp_target  <= ramp_target_next;
        ramp_active  <= ramp_active_next;
        elapsed      <= elapsed_next;
        m_tvalid     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= s_tuser;
      temp_q <= s_tdata;
    end
    if (cmd.mul_en) begin
      product <= PROD_W'(span) * PROD_W'(elapsed_inc);
      dir_up  <= up;
    end
    if (cmd.div_load) begin
      rem  <= product[PROD_W-1:FX_W];
      quot <= product[FX_W-1:0];
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, len_eff}) begin
        rem  <= LEN_W'(trial - {1'b0, len_eff});
        quot <= {quot[FX_W-2:0], 1'b1};
      end else begin
        rem  <= trial[LEN_W-1:0];
        quot <= {quot[FX_W-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      m_tuser <= wrote;
      m_tdata <= {7'd0, ramp_active_next, last_written_next[FX_W-1:FRAC_BITS], shown};
    end
  end

endmodule
`default_nettype wire

>>> hdl/color_temperature_setpoint_smoother_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_temperature_setpoint_smoother_unit
// Setpoint ramp with deadband for a display color temperature.
//
// Input transactions carry a command kind on s_tuser (smooth set, immediate
// set or time tick) and a temperature in whole Kelvin on s_tdata. Every input
// transaction yields exactly one output transaction with the write flag,
// the displayed value, the current value and the ramp status.
// Set commands and ticks that finish or skip a ramp pass from acceptance
// through the evaluate and finish states to a valid output. A tick in the
// middle of a ramp also passes the load and divide states: the step product
// is divided by the ramp length in a radix-2 divider that resolves one of 24
// quotient bits per cycle. One transaction is worked on at a time; s_tready
// rises again the cycle after the output register is loaded.
// The output register holds its result while m_tready is low; a finished
// result waits in the finish state until the register is free, and the next
// input can be accepted while only the output register holds a result.
// Reset restores the deadband (10 K) and ramp length (100 ticks), sets the
// current value and target to 6500 K and stops any ramp. Users must write the
// configuration port while no transaction is in flight; not enforced here.
// ----------------------------------------------------------------------------
module color_temperature_setpoint_smoother_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ctss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ctss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [15:0] temperature
  input  wire logic [ctss_pkg::TEMP_W-1:0]      s_tdata,
  // [1:0] kind
  input  wire logic [ctss_pkg::KIND_W-1:0]      s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [15:0] display_temperature, [31:16] current_temperature, [32] ramping
  output logic [ctss_pkg::OUT_DATA_W-1:0]       m_tdata,
  // [0] write_valid
  output logic                                  m_tuser
);
  import ctss_pkg::*;

  ctss_cmd_t    cmd;
  ctss_status_t status;

  ctss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ctss_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
`default_nettype wire
